@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file qdi_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPL(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ rtl/core/qdi_pkg.sv @@
// widths, status codes and pipeline record types for quad_diagonal_intersection
// no dependencies
package qdi_pkg;

  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int QW = DW;
  localparam int MW = DW + NW;
  localparam int SW = QW + 3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_VERT = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]           code;
    logic signed [CW-1:0] p0x;
    logic signed [CW-1:0] p0y;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
  } base_t;

  typedef struct packed {
    logic [NW-1:0] r;
    logic [QW-1:0] nl;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic [1:0]           code;
    logic                 dz;
    logic signed [CW-1:0] p0x;
    logic signed [CW-1:0] p0y;
    logic [NW-1:0]        d;
    lane_t                lx;
    lane_t                ly;
  } div_t;

  function automatic lane_t lane_step(lane_t a, logic [NW-1:0] d);
    logic [NW:0] t;
    logic        ge;
    lane_t       o;
    t = {a.r, a.nl[QW-1]};
    ge = t >= {1'b0, d};
    o = a;
    o.r = ge ? NW'(t - {1'b0, d}) : NW'(t);
    o.nl = a.nl << 1;
    o.q = {a.q[QW-2:0], ge};
    return o;
  endfunction

  function automatic lane_t lane_init(logic signed [MW-1:0] n, logic [NW-1:0] dm,
                                      logic dneg);
    logic [MW-1:0] m;
    lane_t         o;
    m = n[MW-1] ? MW'(-n) : MW'(n);
    o.r = m[MW-1:QW];
    o.nl = m[QW-1:0];
    o.q = '0;
    o.neg = n[MW-1] ^ dneg;
    o.ovf = m >= {dm, {QW{1'b0}}};
    return o;
  endfunction

  // round, apply sign, add the base corner and clamp
  function automatic logic [CW:0] lane_final(lane_t a, logic [NW-1:0] d,
                                             logic signed [CW-1:0] p0);
    logic                  rnd;
    logic [QW:0]           qr;
    logic signed [SW-1:0]  sv;
    logic signed [SW-1:0]  sum;
    logic                  sat;
    logic signed [CW-1:0]  v;
    rnd = {a.r, 1'b0} >= {1'b0, d};
    qr = {1'b0, a.q} + (QW+1)'(rnd);
    sv = a.neg ? -SW'(qr) : SW'(qr);
    sum = SW'(p0) + sv;
    sat = 1'b0;
    if (a.ovf) begin
      sat = 1'b1;
      v = a.neg ? CMIN : CMAX;
    end else if (sum > SW'(CMAX)) begin
      sat = 1'b1;
      v = CMAX;
    end else if (sum < SW'(CMIN)) begin
      sat = 1'b1;
      v = CMIN;
    end else begin
      v = CW'(sum);
    end
    return {sat, v};
  endfunction

endpackage

@@ rtl/core/quad_diagonal_intersection.sv @@
// quadrilateral diagonal crossing point, pipelined datapath with restoring dividers
// depends on qdi_pkg
//
//   channel | direction | handshake            | fields
//   in      | input     | in_valid / in_stall   | corner0_x .. corner3_y
//   out     | output    | out_valid / out_stall | center_x, center_y, status
//
// one item per cycle while the output is not stalled; each item passes through
// 5 setup and multiply stages, one stage per quotient bit and one output stage
// the quotient bit stages of the two dividers set the latency
// rst clears all valid bits; payload registers are not reset
// a stall on a valid output freezes the whole pipe and is passed back as in_stall
module quad_diagonal_intersection (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [qdi_pkg::CW-1:0] corner0_x,
  input  logic signed [qdi_pkg::CW-1:0] corner0_y,
  input  logic signed [qdi_pkg::CW-1:0] corner1_x,
  input  logic signed [qdi_pkg::CW-1:0] corner1_y,
  input  logic signed [qdi_pkg::CW-1:0] corner2_x,
  input  logic signed [qdi_pkg::CW-1:0] corner2_y,
  input  logic signed [qdi_pkg::CW-1:0] corner3_x,
  input  logic signed [qdi_pkg::CW-1:0] corner3_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [qdi_pkg::CW-1:0] center_x,
  output logic signed [qdi_pkg::CW-1:0] center_y,
  output logic [1:0]                   status
);

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: differences and special cases
  qdi_pkg::base_t                b1;
  logic signed [qdi_pkg::DW-1:0] bx1, by1, ex1, ey1;
  logic                          v1;
  logic                          dup;
  logic [1:0]                    code_n;

  always_comb begin
    dup = (corner0_x == corner1_x && corner0_y == corner1_y)
       || (corner0_x == corner2_x && corner0_y == corner2_y)
       || (corner0_x == corner3_x && corner0_y == corner3_y)
       || (corner1_x == corner2_x && corner1_y == corner2_y)
       || (corner1_x == corner3_x && corner1_y == corner3_y)
       || (corner2_x == corner3_x && corner2_y == corner3_y);
    if (dup) code_n = qdi_pkg::ST_DUP;
    else if (corner0_x == corner2_x && corner1_x == corner3_x) code_n = qdi_pkg::ST_VERT;
    else code_n = qdi_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      b1.code <= code_n;
      b1.p0x <= corner0_x;
      b1.p0y <= corner0_y;
      b1.ax <= qdi_pkg::DW'(corner2_x) - qdi_pkg::DW'(corner0_x);
      b1.ay <= qdi_pkg::DW'(corner2_y) - qdi_pkg::DW'(corner0_y);
      bx1 <= qdi_pkg::DW'(corner3_x) - qdi_pkg::DW'(corner1_x);
      by1 <= qdi_pkg::DW'(corner3_y) - qdi_pkg::DW'(corner1_y);
      ex1 <= qdi_pkg::DW'(corner1_x) - qdi_pkg::DW'(corner0_x);
      ey1 <= qdi_pkg::DW'(corner1_y) - qdi_pkg::DW'(corner0_y);
    end
  end

  // stage 2: cross products
  qdi_pkg::base_t                b2;
  logic signed [qdi_pkg::PW-1:0] pa, pb, pc, pd;
  logic                          v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      b2 <= b1;
      pa <= b1.ax * by1;
      pb <= b1.ay * bx1;
      pc <= ex1 * by1;
      pd <= ey1 * bx1;
    end
  end

  // stage 3: denominator and numerator
  qdi_pkg::base_t                b3;
  logic signed [qdi_pkg::NW-1:0] den3, num3;
  logic                          v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      b3 <= b2;
      den3 <= qdi_pkg::NW'(pa) - qdi_pkg::NW'(pb);
      num3 <= qdi_pkg::NW'(pc) - qdi_pkg::NW'(pd);
    end
  end

  // stage 4: scaled numerators
  qdi_pkg::base_t                b4;
  logic signed [qdi_pkg::NW-1:0] den4;
  logic signed [qdi_pkg::MW-1:0] nx4, ny4;
  logic                          v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      b4 <= b3;
      den4 <= den3;
      nx4 <= b3.ax * num3;
      ny4 <= b3.ay * num3;
    end
  end

  // stage 5: magnitudes, signs and range check, divider setup
  qdi_pkg::div_t dv [qdi_pkg::QW+1];
  logic          vd [qdi_pkg::QW+1];
  logic [qdi_pkg::NW-1:0] dmag;

  assign dmag = den4[qdi_pkg::NW-1] ? qdi_pkg::NW'(-den4) : qdi_pkg::NW'(den4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (adv) begin
      vd[0] <= v4;
    end
    if (adv) begin
      dv[0].code <= b4.code;
      dv[0].dz <= (den4 == '0);
      dv[0].p0x <= b4.p0x;
      dv[0].p0y <= b4.p0y;
      dv[0].d <= dmag;
      dv[0].lx <= qdi_pkg::lane_init(nx4, dmag, den4[qdi_pkg::NW-1]);
      dv[0].ly <= qdi_pkg::lane_init(ny4, dmag, den4[qdi_pkg::NW-1]);
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < qdi_pkg::QW; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s+1] <= 1'b0;
      end else if (adv) begin
        vd[s+1] <= vd[s];
      end
      if (adv) begin
        dv[s+1].code <= dv[s].code;
        dv[s+1].dz <= dv[s].dz;
        dv[s+1].p0x <= dv[s].p0x;
        dv[s+1].p0y <= dv[s].p0y;
        dv[s+1].d <= dv[s].d;
        dv[s+1].lx <= qdi_pkg::lane_step(dv[s].lx, dv[s].d);
        dv[s+1].ly <= qdi_pkg::lane_step(dv[s].ly, dv[s].d);
      end
    end
  end

  // output stage
  logic [qdi_pkg::CW:0] fx, fy;
  assign fx = qdi_pkg::lane_final(dv[qdi_pkg::QW].lx, dv[qdi_pkg::QW].d, dv[qdi_pkg::QW].p0x);
  assign fy = qdi_pkg::lane_final(dv[qdi_pkg::QW].ly, dv[qdi_pkg::QW].d, dv[qdi_pkg::QW].p0y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd[qdi_pkg::QW];
    end
    if (adv) begin
      if (dv[qdi_pkg::QW].code != qdi_pkg::ST_OK) begin
        center_x <= '0;
        center_y <= '0;
        status <= dv[qdi_pkg::QW].code;
      end else if (dv[qdi_pkg::QW].dz) begin
        center_x <= '0;
        center_y <= '0;
        status <= qdi_pkg::ST_SAT;
      end else begin
        center_x <= fx[qdi_pkg::CW-1:0];
        center_y <= fy[qdi_pkg::CW-1:0];
        status <= (fx[qdi_pkg::CW] || fy[qdi_pkg::CW]) ? qdi_pkg::ST_SAT : qdi_pkg::ST_OK;
      end
    end
  end

endmodule

@@ rtl/core/qdi_checker.sv @@
// port-level checks for quad_diagonal_intersection, bound to the top level
// depends on qdi_pkg and assert_macros.svh
`include "assert_macros.svh"

module qdi_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [qdi_pkg::CW-1:0] center_x,
  input logic signed [qdi_pkg::CW-1:0] center_y,
  input logic [1:0]                   status
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_pay_hold, clk, rst, out_valid && out_stall, $stable(center_x) && $stable(center_y) && $stable(status))
  `ASSERT_IMPL(a_stall_back, clk, rst, 1'b1, in_stall == (out_valid && out_stall))
  `ASSERT_IMPL(a_err_zero, clk, rst, out_valid && (status == qdi_pkg::ST_DUP || status == qdi_pkg::ST_VERT), center_x == '0 && center_y == '0)

endmodule

bind quad_diagonal_intersection qdi_checker u_qdi_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .center_x(center_x),
  .center_y(center_y),
  .status(status)
);
